// ===== rtl/core/tsf_pkg.sv =====
// Shared types, constants and helpers for the touch sample trimmed-mean filter.
`default_nettype none

package tsf_pkg;

    // Sample and register widths
    localparam int unsigned SAMPLE_W = 13;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 2;

    // Samples per group: the last slot index closes the group
    localparam logic [COUNT_W-1:0] GROUP_LAST  = 2'd3;
    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 13'd5;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Middle pair of a sorted group, passed from the compare stage to the output stage
    typedef struct packed {
        t_sample lo;
        t_sample hi;
        logic    axis;
    } t_mid_pair;

    // Join the raw bytes high first and drop the three low bits
    function automatic t_sample form_sample(
        input logic [BYTE_W-1:0] high_byte,
        input logic [BYTE_W-1:0] low_byte
    );
        logic [2*BYTE_W-1:0] word;
        word = {high_byte, low_byte};
        return word[2*BYTE_W-1:3];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsf_in_if.sv =====
// Input channel: raw conversion bytes and axis.
`default_nettype none

interface tsf_in_if;
    logic                      valid;
    logic                      ready;
    logic [tsf_pkg::BYTE_W-1:0] high_byte;
    logic [tsf_pkg::BYTE_W-1:0] low_byte;
    logic                      axis;

    modport source (output valid, output high_byte, output low_byte, output axis,
                    input ready);
    modport sink   (input valid, input high_byte, input low_byte, input axis,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tsf_out_if.sv =====
// Output channel: filtered position, reject flag and axis.
`default_nettype none

interface tsf_out_if;
    logic             valid;
    logic             ready;
    tsf_pkg::t_sample position;
    logic             rejected;
    logic             axis_out;

    modport source (output valid, output position, output rejected, output axis_out,
                    input ready);
    modport sink   (input valid, input position, input rejected, input axis_out,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tsf_cfg_if.sv =====
// Configuration write channel: spread limit data.
`default_nettype none

interface tsf_cfg_if;
    logic             valid;
    logic             ready;
    tsf_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tsf_cell.sv =====
// One sample cell of the holding chain: loads from its left neighbor on shift.
`default_nettype none

module tsf_cell (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire tsf_pkg::t_sample i_d,
    output tsf_pkg::t_sample      o_q
);

    tsf_pkg::t_sample r_q;

    // Sample register, moves one place down the chain per accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/tsf_mid_pair.sv =====
// Compare network picking the two middle values of four samples, registered.
`default_nettype none

module tsf_mid_pair (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic             i_load,
    input  wire tsf_pkg::t_sample i_a,
    input  wire tsf_pkg::t_sample i_b,
    input  wire tsf_pkg::t_sample i_c,
    input  wire tsf_pkg::t_sample i_d,
    input  wire logic             i_axis,
    output logic                  o_valid,
    output tsf_pkg::t_mid_pair    o_pair
);

    tsf_pkg::t_sample  lo_ab, hi_ab, lo_cd, hi_cd;
    tsf_pkg::t_sample  inner_a, inner_b;
    tsf_pkg::t_mid_pair n_pair;
    tsf_pkg::t_mid_pair r_pair;
    logic               r_valid;

    // First layer sorts the two pairs; second layer keeps the inner values;
    // third layer orders the inner pair
    always_comb begin
        lo_ab = (i_a > i_b) ? i_b : i_a;
        hi_ab = (i_a > i_b) ? i_a : i_b;
        lo_cd = (i_c > i_d) ? i_d : i_c;
        hi_cd = (i_c > i_d) ? i_c : i_d;
        inner_a = (lo_ab > lo_cd) ? lo_ab : lo_cd;  // larger of the two minima
        inner_b = (hi_ab > hi_cd) ? hi_cd : hi_ab;  // smaller of the two maxima
        n_pair.lo   = (inner_a > inner_b) ? inner_b : inner_a;
        n_pair.hi   = (inner_a > inner_b) ? inner_a : inner_b;
        n_pair.axis = i_axis;
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_load;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pair <= n_pair;
        end
    end

    assign o_valid = r_valid;
    assign o_pair  = r_pair;

endmodule

`default_nettype wire

// ===== rtl/core/touch_sample_trimmed_mean_filter_unit.sv =====
// Top level of the touch sample trimmed-mean filter.
//
// Takes one raw conversion per cycle, forms a 13-bit sample from its two
// bytes and collects samples in groups of four. Three sample cells in a
// chain hold the first samples of a group; the fourth sample goes straight
// with them into a compare network that picks the two middle values, and a
// second stage checks their spread against the limit and averages them.
// The block accepts one transaction per clock while the output side keeps
// up, giving one result per four accepted samples; the fourth sample of a
// group passes the compare register, then the output register.
// A stalled output holds the pipeline only once both stages are full.
// The spread limit resets to 5 and is written over the configuration
// channel, which is always ready.
`default_nettype none

module touch_sample_trimmed_mean_filter_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsf_in_if.sink    i_in,
    tsf_cfg_if.sink   i_cfg,
    tsf_out_if.source o_out
);

    localparam int unsigned CELLS = 3;

    tsf_pkg::t_sample                  new_sample;
    tsf_pkg::t_sample                  cell_q [CELLS];
    tsf_pkg::t_sample                  cell_d [CELLS];
    logic                              in_fire;
    logic                              group_done;
    logic                              out_free;
    logic                              s1_free;
    logic                              s1_valid;
    tsf_pkg::t_mid_pair                s1_pair;
    logic [tsf_pkg::COUNT_W-1:0]       r_count;
    tsf_pkg::t_sample                  r_spread_limit;
    logic                              r_out_valid;
    tsf_pkg::t_sample                  r_position;
    logic                              r_rejected;
    logic                              r_axis_out;
    tsf_pkg::t_sample                  spread;
    logic [tsf_pkg::SAMPLE_W:0]        mid_sum;

    // Flow control: each stage moves when the one after it has room
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_free    = !s1_valid || out_free;
    assign i_in.ready = s1_free;
    assign in_fire    = i_in.valid && s1_free;
    assign group_done = in_fire && (r_count == tsf_pkg::GROUP_LAST);
    assign new_sample = tsf_pkg::form_sample(i_in.high_byte, i_in.low_byte);

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread_limit <= tsf_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_spread_limit <= i_cfg.data;
        end
    end

    // Group position counter, wraps after the fourth sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_fire) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Sample holding chain
    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_d[g] = new_sample;
            end else begin : g_link
                assign cell_d[g] = cell_q[g-1];
            end
            tsf_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (in_fire),
                .i_d     (cell_d[g]),
                .o_q     (cell_q[g])
            );
        end
    endgenerate

    // Middle pair of the completed group
    tsf_mid_pair u_mid_pair (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_free),
        .i_load    (group_done),
        .i_a       (cell_q[0]),
        .i_b       (cell_q[1]),
        .i_c       (cell_q[2]),
        .i_d       (new_sample),
        .i_axis    (i_in.axis),
        .o_valid   (s1_valid),
        .o_pair    (s1_pair)
    );

    // Spread check and truncated mean
    assign spread  = s1_pair.hi - s1_pair.lo;
    assign mid_sum = {1'b0, s1_pair.lo} + {1'b0, s1_pair.hi};

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_free && s1_valid) begin
            r_axis_out <= s1_pair.axis;
            if (spread > r_spread_limit) begin
                r_position <= '0;
                r_rejected <= 1'b1;
            end else begin
                r_position <= mid_sum[tsf_pkg::SAMPLE_W:1];
                r_rejected <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_position;
    assign o_out.rejected = r_rejected;
    assign o_out.axis_out = r_axis_out;

endmodule

`default_nettype wire

// ===== tb/touch_sample_trimmed_mean_filter_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: group filter prediction, handshake stalls and spread-limit settings.
module touch_sample_trimmed_mean_filter_unit_test;

    localparam int               PIPE_LATENCY     = 2;
    localparam int               SETTLE_CYCLES    = PIPE_LATENCY + 3;
    localparam int               HOLD_CYCLES      = 64;
    localparam int               GAP_MAX          = 6;
    localparam int               BURST_MAX        = 12;
    localparam int               GROUPS_PER_PHASE = 25;
    localparam int               NUM_PHASES       = 5;
    localparam tsf_pkg::t_sample SAMPLE_MAX       = '1;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;
    typedef enum int {SHAPE_WIDE, SHAPE_EDGE, SHAPE_CLUSTER, SHAPE_PAIR} t_group_shape;

    typedef struct packed {
        tsf_pkg::t_sample position;
        logic             rejected;
        logic             axis_out;
    } t_filter_result;

    logic i_clk;
    logic i_rst_n;

    tsf_in_if  in_ch ();
    tsf_cfg_if cfg_ch ();
    tsf_out_if out_ch ();

    touch_sample_trimmed_mean_filter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Predictor state: spread limit, held samples of the open group, fill count
    tsf_pkg::t_sample            limit_now = tsf_pkg::LIMIT_RESET;
    tsf_pkg::t_sample            held_now[3];
    logic [tsf_pkg::COUNT_W-1:0] fill_now  = '0;
    t_filter_result              pending_results[$];

    int error_count  = 0;
    int sample_count = 0;
    int result_count = 0;
    int reject_count = 0;
    int limit_writes = 0;

    // Stimulus control
    bit               gaps_on       = 1'b0;
    int               burst_left    = 0;
    tsf_pkg::t_sample limit_setting = tsf_pkg::LIMIT_RESET;
    t_rx_mode         rx_mode       = RX_ALWAYS;
    int               hold_req      = 0;
    int               hold_seen     = 0;
    int               hold_left     = 0;
    int               rx_phase      = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Sort four samples, compare the middle pair against the limit
    function automatic t_filter_result trimmed_mean(
        input tsf_pkg::t_sample a, input tsf_pkg::t_sample b,
        input tsf_pkg::t_sample c, input tsf_pkg::t_sample d,
        input logic ax, input tsf_pkg::t_sample lim
    );
        tsf_pkg::t_sample          v[4];
        tsf_pkg::t_sample          swap_val;
        logic [tsf_pkg::SAMPLE_W:0] mid_sum;
        t_filter_result            r;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        for (int i = 0; i < 3; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if (v[i] > v[j]) begin
                    swap_val = v[i];
                    v[i]     = v[j];
                    v[j]     = swap_val;
                end
            end
        end
        if (v[2] - v[1] > lim) begin
            r.position = '0;
            r.rejected = 1'b1;
        end else begin
            mid_sum    = {1'b0, v[1]} + {1'b0, v[2]};
            r.position = mid_sum[tsf_pkg::SAMPLE_W:1];
            r.rejected = 1'b0;
        end
        r.axis_out = ax;
        return r;
    endfunction

    // Monitor: track limit writes, check outputs, predict on accepted samples
    always @(posedge i_clk) begin : monitor
        t_filter_result               want;
        tsf_pkg::t_sample             s;
        logic [2*tsf_pkg::BYTE_W-1:0] word;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                limit_now = cfg_ch.data;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected output transaction: position %0d rejected %0b axis %0b",
                           out_ch.position, out_ch.rejected, out_ch.axis_out);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    result_count++;
                    if (want.rejected) begin
                        reject_count++;
                    end
                    if (out_ch.position !== want.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, out_ch.position);
                        error_count++;
                    end
                    if (out_ch.rejected !== want.rejected) begin
                        $error("rejected mismatch: expected %0b, actual %0b",
                               want.rejected, out_ch.rejected);
                        error_count++;
                    end
                    if (out_ch.axis_out !== want.axis_out) begin
                        $error("axis_out mismatch: expected %0b, actual %0b",
                               want.axis_out, out_ch.axis_out);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                word = {in_ch.high_byte, in_ch.low_byte};
                s    = tsf_pkg::t_sample'(word >> 3);
                sample_count++;
                if (fill_now == tsf_pkg::GROUP_LAST) begin
                    pending_results.push_back(trimmed_mean(held_now[0], held_now[1], held_now[2],
                                                           s, in_ch.axis, limit_now));
                    fill_now = '0;
                end else begin
                    held_now[fill_now] = s;
                    fill_now++;
                end
            end
        end
    end

    // Output side: long hold-off on request, otherwise the selected stall pattern
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        rx_phase = (rx_phase + 1) % 7;
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    out_ch.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    out_ch.ready <= (rx_phase >= 2);
                end
            endcase
        end
    end

    // One input transaction; may open a random gap after it
    task automatic send_raw(input logic [tsf_pkg::BYTE_W-1:0] hi,
                            input logic [tsf_pkg::BYTE_W-1:0] lo,
                            input logic ax);
        in_ch.valid     <= 1'b1;
        in_ch.high_byte <= hi;
        in_ch.low_byte  <= lo;
        in_ch.axis      <= ax;
        do @(posedge i_clk); while (!in_ch.ready);
        if (gaps_on) begin
            if (burst_left == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
                burst_left = $urandom_range(1, BURST_MAX);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Send a 13-bit sample; the three dropped low bits get random values
    task automatic send_value(input tsf_pkg::t_sample s, input logic ax);
        logic [2:0] pad;
        pad = 3'($urandom);
        send_raw(s[tsf_pkg::SAMPLE_W-1:5], {s[4:0], pad}, ax);
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    // Stop sending and wait until every expected result has been checked
    task automatic drain_results();
        idle_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input tsf_pkg::t_sample lim);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= lim;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_setting = lim;
        limit_writes++;
    endtask

    // Four samples of a random shape, in shuffled order with random axes
    task automatic send_random_group();
        int unsigned  vals[4];
        int unsigned  lo_mid;
        int unsigned  span;
        int unsigned  tmp;
        int           j;
        t_group_shape shape;
        shape = t_group_shape'($urandom_range(0, 3));
        case (shape)
            SHAPE_WIDE: begin
                for (int k = 0; k < 4; k++) vals[k] = $urandom_range(0, SAMPLE_MAX);
            end
            SHAPE_EDGE: begin
                // middle pair one below, at, or one above the limit
                span = limit_setting + $urandom_range(0, 2);
                if (span > 0) span--;
                if (span > SAMPLE_MAX) span = SAMPLE_MAX;
                lo_mid  = $urandom_range(0, SAMPLE_MAX - span);
                vals[0] = $urandom_range(0, lo_mid);
                vals[1] = lo_mid;
                vals[2] = lo_mid + span;
                vals[3] = $urandom_range(lo_mid + span, SAMPLE_MAX);
            end
            SHAPE_CLUSTER: begin
                tmp = $urandom_range(0, SAMPLE_MAX - 3);
                for (int k = 0; k < 4; k++) vals[k] = tmp + $urandom_range(0, 3);
            end
            default: begin
                tmp     = $urandom_range(0, SAMPLE_MAX);
                vals[0] = tmp;
                vals[1] = tmp;
                vals[2] = $urandom_range(0, SAMPLE_MAX);
                vals[3] = $urandom_range(0, SAMPLE_MAX);
            end
        endcase
        for (int k = 3; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = vals[k];
            vals[k] = vals[j];
            vals[j] = tmp;
        end
        for (int k = 0; k < 4; k++) send_value(tsf_pkg::t_sample'(vals[k]), 1'($urandom));
    endtask

    // Reset limit: spread equal to the limit passes, one more is rejected with mixed axes
    task automatic test_default_limit_edge();
        send_value(13'd100, 1'b0);
        send_value(13'd105, 1'b0);
        send_value(13'd0, 1'b0);
        send_value(SAMPLE_MAX, 1'b1);
        send_value(13'd106, 1'b1);
        send_value(13'd100, 1'b0);
        send_value(SAMPLE_MAX, 1'b1);
        send_value(13'd0, 1'b0);
    endtask

    // All-ones and all-zeros bytes
    task automatic test_byte_extremes();
        send_raw(8'hFF, 8'hFF, 1'b1);
        send_raw(8'hFF, 8'hFF, 1'b0);
        send_raw(8'hFF, 8'hFF, 1'b1);
        send_raw(8'h00, 8'h00, 1'b0);
        send_raw(8'h00, 8'h00, 1'b1);
        send_raw(8'h00, 8'h00, 1'b0);
        send_raw(8'hFF, 8'h00, 1'b1);
        send_raw(8'h00, 8'hFF, 1'b1);
    endtask

    // Limit of zero, then full-range limit written in the middle of a group
    task automatic test_limit_extremes();
        drain_results();
        write_limit('0);
        send_value(13'd50, 1'b1);
        send_value(13'd50, 1'b0);
        send_value(13'd20, 1'b1);
        send_value(13'd60, 1'b0);
        send_value(13'd0, 1'b1);
        send_value(SAMPLE_MAX, 1'b0);
        drain_results();
        write_limit(SAMPLE_MAX);
        send_value(13'd0, 1'b0);
        send_value(SAMPLE_MAX, 1'b1);
    endtask

    // Output held off for a long stretch while the input keeps offering samples
    task automatic test_output_backpressure();
        drain_results();
        gaps_on = 1'b0;
        rx_mode <= RX_ALWAYS;
        hold_req <= hold_req + 1;
        for (int g = 0; g < 10; g++) send_random_group();
        drain_results();
    endtask

    // Random groups over several limit settings and idle patterns
    task automatic test_random_groups();
        tsf_pkg::t_sample lim;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: lim = tsf_pkg::t_sample'($urandom_range(0, 16));
                1: lim = SAMPLE_MAX;
                2: lim = '0;
                3: lim = tsf_pkg::t_sample'($urandom_range(0, SAMPLE_MAX));
                default: lim = tsf_pkg::t_sample'($urandom_range(17, 300));
            endcase
            write_limit(lim);
            gaps_on    = (phase % 2 == 1);
            burst_left = $urandom_range(1, BURST_MAX);
            rx_mode <= t_rx_mode'(phase % 3);
            for (int g = 0; g < GROUPS_PER_PHASE; g++) begin
                send_random_group();
                // stray sample shifts the group boundary
                if ($urandom_range(0, 11) == 0) begin
                    send_raw(8'($urandom), 8'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 19) == 0) begin
                    drain_results();
                end
                if ($urandom_range(0, 49) == 0) begin
                    hold_req <= hold_req + 1;
                end
            end
        end
    endtask

    // Main sequence
    initial begin : main_seq
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.high_byte = '0;
        in_ch.low_byte  = '0;
        in_ch.axis      = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_limit_edge();
        test_byte_extremes();
        test_limit_extremes();
        test_output_backpressure();
        test_random_groups();
        drain_results();

        $display("Run covered %0d samples and %0d checked group outputs, %0d of them rejected.",
                 sample_count, result_count, reject_count);
        $display("Spread limit written %0d times (0 and %0d among them);",
                 limit_writes, SAMPLE_MAX);
        $display("input gaps, output stalls and a %0d-cycle hold-off were exercised.",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
